// ----- rtl/core/hed_pkg.sv -----
// Shared types and character codes for the HTML entity decoder.
// Used by hed_front, hed_queue, hed_back and html_entity_decoder; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hed_pkg;

  localparam int HOLD_DEPTH  = 6;
  localparam int JOB_BYTES   = HOLD_DEPTH + 1;
  localparam int QUEUE_DEPTH = 4;

  localparam logic [7:0] CH_AMP   = 8'h26;  // '&'
  localparam logic [7:0] CH_SEMI  = 8'h3B;  // ';'
  localparam logic [7:0] CH_QUOT  = 8'h22;  // '"'
  localparam logic [7:0] CH_APOS  = 8'h27;  // '\''
  localparam logic [7:0] CH_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_LT    = 8'h3C;  // '<'

  // One job: the output bytes caused by one item, in order.
  typedef struct packed {
    logic [JOB_BYTES-1:0][7:0] bytes;
    logic [2:0]                count;
    logic                      eot;
  } hed_job_t;

endpackage

`default_nettype wire

// ----- rtl/core/hed_front.sv -----
// Front end: accepts text bytes, keeps the entity hold buffer and turns each
// item into one output job. Depends on hed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hed_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire logic [7:0]       text_byte,
  input  wire logic             end_of_text,
  input  wire logic             queue_full,
  output logic                  job_write,
  output hed_pkg::hed_job_t     job
);

  logic [hed_pkg::HOLD_DEPTH-1:0][7:0] hold;
  logic [hed_pkg::HOLD_DEPTH-1:0][7:0] hold_next;
  logic [2:0]                          cnt;
  logic [2:0]                          cnt_next;
  logic                                fire;
  logic                                is_amp;
  logic                                is_semi;
  logic                                hit;
  logic [7:0]                          rep;

  assign in_stall = queue_full;
  assign fire     = in_valid && !queue_full;
  assign is_amp   = (text_byte == hed_pkg::CH_AMP);
  assign is_semi  = (text_byte == hed_pkg::CH_SEMI);

  // Entity lookup on the held letters; entry 0 is always the ampersand.
  always_comb begin
    hit = 1'b1;
    rep = hed_pkg::CH_AMP;
    if (cnt == 3'd5 && hold[1] == "q" && hold[2] == "u" && hold[3] == "o" &&
        hold[4] == "t") begin
      rep = hed_pkg::CH_QUOT;
    end else if (cnt == 3'd5 && hold[1] == "a" && hold[2] == "p" && hold[3] == "o" &&
                 hold[4] == "s") begin
      rep = hed_pkg::CH_APOS;
    end else if (cnt == 3'd6 && hold[1] == "f" && hold[2] == "r" && hold[3] == "a" &&
                 hold[4] == "s" && hold[5] == "l") begin
      rep = hed_pkg::CH_SLASH;
    end else if (cnt == 3'd3 && hold[1] == "g" && hold[2] == "t") begin
      rep = hed_pkg::CH_GT;
    end else if (cnt == 3'd3 && hold[1] == "l" && hold[2] == "t") begin
      rep = hed_pkg::CH_LT;
    end else if (cnt == 3'd4 && hold[1] == "a" && hold[2] == "m" && hold[3] == "p") begin
      rep = hed_pkg::CH_AMP;
    end else begin
      hit = 1'b0;
    end
  end

  always_comb begin
    // The job bytes are the held bytes followed by the new byte; the count
    // decides how many of them go out.
    for (int i = 0; i < hed_pkg::HOLD_DEPTH; i++) begin
      job.bytes[i] = (3'(i) < cnt) ? hold[i] : text_byte;
    end
    job.bytes[hed_pkg::JOB_BYTES-1] = text_byte;
    job.eot   = end_of_text;
    job.count = 3'd0;
    hold_next = hold;
    cnt_next  = cnt;

    if (cnt == 3'd0) begin
      if (is_amp) begin
        hold_next[0] = text_byte;
        cnt_next     = 3'd1;
      end else begin
        job.count = 3'd1;
      end
    end else if (is_amp) begin
      job.count    = cnt;
      hold_next[0] = text_byte;
      cnt_next     = 3'd1;
    end else if (is_semi) begin
      cnt_next = 3'd0;
      if (hit) begin
        job.bytes[0] = rep;
        job.count    = 3'd1;
      end else begin
        job.count = cnt + 3'd1;
      end
    end else if (cnt >= 3'(hed_pkg::HOLD_DEPTH)) begin
      job.count = cnt + 3'd1;
      cnt_next  = 3'd0;
    end else begin
      hold_next[cnt] = text_byte;
      cnt_next       = cnt + 3'd1;
    end

    // At end of text everything goes out: the held bytes and the new byte,
    // unless the semicolon just completed an entity.
    if (end_of_text) begin
      cnt_next = 3'd0;
      if (!(cnt != 3'd0 && is_semi && hit)) begin
        job.count = cnt + 3'd1;
      end
    end
  end

  assign job_write = fire && (job.count != 3'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 3'd0;
    end else if (fire) begin
      cnt <= cnt_next;
    end
    if (fire) begin
      hold <= hold_next;
    end
  end

`ifndef SYNTH
  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= 3'(hed_pkg::HOLD_DEPTH))
    else $error("hold count beyond buffer depth");
  a_eot_clears: assert property (@(posedge clk) disable iff (rst)
    fire && end_of_text |=> cnt == 3'd0)
    else $error("hold not empty after end of text");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/hed_queue.sv -----
// Short job queue between the front end and the back end of the decoder.
// Register based, first in first out. Depends on hed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hed_queue #(
  parameter int QUEUE_DEPTH = hed_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              wr,
  input  wire hed_pkg::hed_job_t wr_job,
  input  wire logic              rd,
  output hed_pkg::hed_job_t      head,
  output logic                   head_valid,
  output logic                   full
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  hed_pkg::hed_job_t entries [QUEUE_DEPTH];
  logic [AW-1:0]     wr_ptr;
  logic [AW-1:0]     rd_ptr;
  logic [CW-1:0]     fill;

  assign head       = entries[rd_ptr];
  assign head_valid = (fill != CW'(0));
  assign full       = (fill == CW'(QUEUE_DEPTH));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr) begin
        wr_ptr <= (wr_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (rd) begin
        rd_ptr <= (rd_ptr == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (wr && !rd) begin
        fill <= fill + CW'(1);
      end else if (rd && !wr) begin
        fill <= fill - CW'(1);
      end
    end
    if (wr) begin
      entries[wr_ptr] <= wr_job;
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) wr |-> !full)
    else $error("job written into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) rd |-> head_valid)
    else $error("job read from an empty queue");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/hed_back.sv -----
// Back end: walks the job at the head of the queue and sends its bytes out
// one per cycle when not stalled, via an output register; uses hed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hed_back (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire hed_pkg::hed_job_t head,
  input  wire logic              head_valid,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [7:0]             out_byte,
  output logic                   end_of_run,
  output logic                   text_done
);

  logic [2:0] idx;
  logic       load;
  logic       last;

  assign load = !out_valid || !out_stall;
  assign last = (idx == head.count - 3'd1);
  assign pop  = load && head_valid && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else if (load) begin
      out_valid <= head_valid;
      if (head_valid) begin
        idx <= last ? 3'd0 : idx + 3'd1;
      end
    end
    if (load && head_valid) begin
      out_byte   <= head.bytes[idx];
      end_of_run <= last;
      text_done  <= last && head.eot;
    end
  end

`ifndef SYNTH
  a_idx_in_job: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> idx < head.count)
    else $error("byte index beyond the current job");
  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && text_done |-> end_of_run)
    else $error("end of text flagged on a byte that does not end its item");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/html_entity_decoder.sv -----
// Streaming HTML entity decoder, top level.
// Instantiates hed_front, hed_queue and hed_back; uses hed_pkg.
//
// Input channel: in_valid, in_stall, text_byte, end_of_text. One text byte
// per item. Output channel: out_valid, out_stall, out_byte, end_of_run,
// text_done. An item gives zero to seven output bytes; end_of_run marks the
// last byte caused by an item and text_done the last byte of the text.
// The front end classifies each byte against the hold buffer in the cycle it
// is accepted and writes one job holding all of its output bytes into a
// queue of QUEUE_DEPTH jobs. The back end sends one byte per cycle while
// out_stall is low. The first byte of an item passes through the queue and
// then the output register. Throughput: one item per cycle while items give
// at most one byte each and the receiver does not stall; an item with several
// output bytes holds the output until all have gone, and the output port, one byte per cycle, sets the sustained rate.
// in_stall rises only when the queue is full. When the receiver stalls, the
// output register holds its byte and the queue absorbs further jobs.
// Reset (rst, synchronous) empties the hold buffer, the queue and the output
// register; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module html_entity_decoder #(
  parameter int QUEUE_DEPTH = hed_pkg::QUEUE_DEPTH
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] text_byte,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_byte,
  output logic            end_of_run,
  output logic            text_done
);

  hed_pkg::hed_job_t job;
  hed_pkg::hed_job_t head;
  logic              job_write;
  logic              queue_full;
  logic              head_valid;
  logic              pop;

  hed_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .queue_full  (queue_full),
    .job_write   (job_write),
    .job         (job)
  );

  hed_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (job_write),
    .wr_job     (job),
    .rd         (pop),
    .head       (head),
    .head_valid (head_valid),
    .full       (queue_full)
  );

  hed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_byte   (out_byte),
    .end_of_run (end_of_run),
    .text_done  (text_done)
  );

endmodule

`default_nettype wire
